### design/deque_with_search_assert.svh
// Assertion macros included by the deque top level.
`ifndef DEQUE_WITH_SEARCH_ASSERT_SVH
`define DEQUE_WITH_SEARCH_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define DWS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define DWS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`endif

### design/dws_pkg.sv
// Constants, codes and index helpers for the double-ended queue.
package dws_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int STAT_W   = 2;
    localparam int OCC_W    = 7;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Next slot round the circular store.
    function automatic idx_t idx_inc(input idx_t idx);
        idx_t r;
        if (idx == idx_t'(CAPACITY - 1)) begin
            r = '0;
        end else begin
            r = idx + 1'b1;
        end
        return r;
    endfunction

    // Previous slot round the circular store.
    function automatic idx_t idx_dec(input idx_t idx);
        idx_t r;
        if (idx == '0) begin
            r = idx_t'(CAPACITY - 1);
        end else begin
            r = idx - 1'b1;
        end
        return r;
    endfunction

    // Slot of the entry at a given position; the position is below the capacity.
    function automatic idx_t idx_add(input idx_t idx, input cnt_t pos);
        logic [IDX_W:0] sum;
        sum = (IDX_W+1)'(idx) + (IDX_W+1)'(pos);
        if (sum >= (IDX_W+1)'(CAPACITY)) begin
            sum = sum - (IDX_W+1)'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

### design/dws_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module dws_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/deque_with_search.sv
// Top level of the bounded double-ended queue with linear search.
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+-----------------------------
//  in      | in_valid / in_ready   | operation, value
//  out     | out_valid / out_ready | status, found, occupancy
//
// Pushes, pops, unused codes and a search on an empty queue are accepted and
// have their result loaded into the output register at the same edge.
// Any other search reads the stored entries from the front through the single
// read port of the entry store, one entry per cycle; each is compared in the
// cycle after its read. A match ends the scan at its compare; otherwise the
// scan closes once every entry has been compared.
// Reset clears the head index, the count and the control state; the entry
// store is not cleared, as only written entries are ever read.
// A new item is taken only when idle and the output register is free or is
// being taken in the same cycle.
module deque_with_search (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [dws_pkg::OP_W-1:0]      operation,
    input  logic signed [dws_pkg::DATA_W-1:0] value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dws_pkg::STAT_W-1:0]    status,
    output logic                          found,
    output logic [dws_pkg::OCC_W-1:0]     occupancy
);

    import dws_pkg::*;

    `include "deque_with_search_assert.svh"

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic                state_reg, state_next;
    idx_t                head_reg, head_next;
    cnt_t                count_reg, count_next;
    cnt_t                pos_reg, pos_next;
    idx_t                addr_reg, addr_next;
    logic                pend_reg, pend_next;
    logic [DATA_W-1:0]   key_reg, key_next;
    logic                out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]   status_reg, status_next;
    logic                found_reg, found_next;
    logic [OCC_W-1:0]    occ_reg, occ_next;

    logic                accept;
    logic                ram_we;
    idx_t                ram_waddr;
    logic                ram_re;
    logic [DATA_W-1:0]   ram_rdata;
    logic                issue;
    logic                hit;
    logic                load_out;
    logic [STAT_W-1:0]   res_status;
    logic                res_found;
    idx_t                new_slot;

    // Entry store.
    dws_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_W)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // Handshake.
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign found     = found_reg;
    assign occupancy = occ_reg;

    // Scan progress: one read issued and one compare made per cycle.
    assign issue  = (state_reg == S_SCAN) && (pos_reg < count_reg);
    assign hit    = (state_reg == S_SCAN) && pend_reg && (ram_rdata == key_reg);
    assign ram_re = issue;

    // Request decode and scan sequencing.
    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        addr_next  = addr_reg;
        pend_next  = 1'b0;
        key_next   = key_reg;
        ram_we     = 1'b0;
        ram_waddr  = head_reg;
        load_out   = 1'b0;
        res_status = ST_OK;
        res_found  = 1'b0;
        new_slot   = idx_dec(head_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    load_out = 1'b1;
                    unique case (operation)
                        OP_PUSH_FRONT:
                        begin
                            if (count_reg == cnt_t'(CAPACITY))
                            begin
                                res_status = ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = new_slot;
                                head_next  = new_slot;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            if (count_reg == cnt_t'(CAPACITY))
                            begin
                                res_status = ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = idx_add(head_reg, count_reg);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status = ST_EMPTY;
                            end
                            else
                            begin
                                head_next  = idx_inc(head_reg);
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status = ST_EMPTY;
                            end
                            else
                            begin
                                load_out   = 1'b0;
                                state_next = S_SCAN;
                                pos_next   = '0;
                                addr_next  = head_reg;
                                key_next   = value;
                            end
                        end
                        default:
                        begin
                            res_status = ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    pend_next = 1'b1;
                    pos_next  = pos_reg + 1'b1;
                    addr_next = idx_inc(addr_reg);
                end
                // Finish on a match, or once every entry has been compared.
                if (hit || (!issue && !pend_reg))
                begin
                    load_out   = 1'b1;
                    res_found  = hit;
                    pend_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        occ_next       = occ_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            status_next    = res_status;
            found_next     = res_found;
            occ_next       = OCC_W'(count_next);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        addr_reg   <= addr_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        occ_reg    <= occ_next;
    end

    // The count never passes the capacity.
    `DWS_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= cnt_t'(CAPACITY))
    // While a search runs, no result waits in the output register.
    `DWS_ASSERT_IMP(a_scan_out_free, state_reg == S_SCAN, !out_valid_reg)
    // A search on a non-empty queue starts a scan and holds back its result.
    `DWS_ASSERT_NXT(a_search_starts,
        accept && operation == OP_SEARCH && count_reg != '0,
        state_reg == S_SCAN && !out_valid_reg)
    // A push into a queue with room grows the count by one.
    `DWS_ASSERT_NXT(a_push_grows,
        accept && (operation == OP_PUSH_FRONT || operation == OP_PUSH_BACK)
            && count_reg != cnt_t'(CAPACITY),
        count_reg == $past(count_reg) + 1'b1)

endmodule
